// ===== hdl/lir_pkg.sv =====
// ---------------------------------------------------------------------------
// lir_pkg: shared types and constants of the linear interpolation resampler
// Item layouts, operation and status codes, fixed field widths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  localparam int DEF_GRID_POINTS = 256;
  localparam int DEF_TIME_STEPS  = 16;
  localparam int DEF_MODEL_SETS  = 12;

  localparam int SETS_PER_FAMILY = 6;

  localparam int WL_W         = 24;
  localparam int FLUX_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int WEIGHT_W     = FRAC_W + 1;
  localparam int DIFF_W       = FLUX_W + 1;
  localparam int PROD_W       = DIFF_W + WEIGHT_W;
  localparam int GRID_COUNT_W = 9;
  localparam int GRID_IDX_W   = 8;
  localparam int TIME_W       = 4;
  localparam int METAL_W      = 4;
  localparam int SET_W        = METAL_W + 1;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = GRID_COUNT_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMF_SELECT = 1'd1;

  localparam logic [GRID_COUNT_W-1:0] GRID_COUNT_RESET = 9'd256;

  typedef enum logic [1:0] {
    MODE_LOAD_GRID = 2'd0,
    MODE_LOAD_FLUX = 2'd1,
    MODE_QUERY     = 2'd2,
    MODE_RESTART   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RANGE_OK    = 2'd0,
    RANGE_ABOVE = 2'd1,
    RANGE_BELOW = 2'd2
  } range_t;

  typedef struct packed {
    mode_t                     mode;
    logic [GRID_IDX_W-1:0]     grid_index;
    logic [TIME_W-1:0]         time_index;
    logic [METAL_W-1:0]        metal_index;
    logic [WL_W-1:0]           wavelength;
    logic signed [FLUX_W-1:0]  flux;
  } in_item_t;

  typedef struct packed {
    logic signed [FLUX_W-1:0]  interpolated_flux;
    range_t                    range_error;
    logic [GRID_IDX_W-1:0]     low_point;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/lir_stream_if.sv =====
// ---------------------------------------------------------------------------
// lir_stream_if: valid/ready channel
// Carries one payload per transaction; source drives valid and payload.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lir_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== hdl/lir_divider.sv =====
// ---------------------------------------------------------------------------
// lir_divider: bit-serial restoring divider for the upper weight
// Produces floor(num * 2^FRAC_W / den) for num < den, one bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lir_divider (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [lir_pkg::WL_W-1:0] num,
  input  wire logic [lir_pkg::WL_W-1:0] den,
  output logic                          done,
  output logic [lir_pkg::FRAC_W-1:0]    quo
);

  import lir_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [WL_W-1:0]  rem;
  logic [WL_W-1:0]  den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [WL_W:0]    rem_shift;
  logic [WL_W:0]    trial;

  assign rem_shift = {rem, 1'b0};
  assign trial     = rem_shift - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(FRAC_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quo   <= '0;
    end else if (busy) begin
      if (!trial[WL_W]) begin
        rem <= trial[WL_W-1:0];
        quo <= {quo[FRAC_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[WL_W-1:0];
        quo <= {quo[FRAC_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lir_serial_mult.sv =====
// ---------------------------------------------------------------------------
// lir_serial_mult: bit-serial signed by unsigned multiplier
// Scans the weight MSB first, doubling and adding the flux difference.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lir_serial_mult (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [lir_pkg::DIFF_W-1:0]   mcand,
  input  wire logic [lir_pkg::WEIGHT_W-1:0] mplier,
  output logic                              done,
  output logic [lir_pkg::PROD_W-1:0]        prod
);

  import lir_pkg::*;

  localparam int CNT_W = $clog2(WEIGHT_W + 1);

  logic [DIFF_W-1:0]   mcand_r;
  logic [WEIGHT_W-1:0] mplier_sr;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic [PROD_W-1:0]   addend;

  assign addend = mplier_sr[WEIGHT_W-1]
                ? {{(PROD_W-DIFF_W){mcand_r[DIFF_W-1]}}, mcand_r}
                : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WEIGHT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r   <= mcand;
      mplier_sr <= mplier;
      prod      <= '0;
    end else if (busy) begin
      prod      <= {prod[PROD_W-2:0], 1'b0} + addend;
      mplier_sr <= {mplier_sr[WEIGHT_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lir_ctrl.sv =====
// ---------------------------------------------------------------------------
// lir_ctrl: sequencer of the resampler
// Holds the grid and flux memories, walks the cursor, drives the divider
// and the serial multiplier, and rounds and saturates the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lir_ctrl #(
  parameter int GRID_POINTS = lir_pkg::DEF_GRID_POINTS,
  parameter int TIME_STEPS  = lir_pkg::DEF_TIME_STEPS,
  parameter int MODEL_SETS  = lir_pkg::DEF_MODEL_SETS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  lir_stream_if.sink                            in_ch,
  input  wire logic [lir_pkg::GRID_COUNT_W-1:0] grid_count,
  input  wire logic                             imf_select,
  output logic                                  div_start,
  output logic [lir_pkg::WL_W-1:0]              div_num,
  output logic [lir_pkg::WL_W-1:0]              div_den,
  input  wire logic                             div_done,
  input  wire logic [lir_pkg::FRAC_W-1:0]       div_quo,
  output logic                                  mult_start,
  output logic [lir_pkg::DIFF_W-1:0]            mult_mcand,
  output logic [lir_pkg::WEIGHT_W-1:0]          mult_mplier,
  input  wire logic                             mult_done,
  input  wire logic [lir_pkg::PROD_W-1:0]       mult_prod,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output lir_pkg::out_item_t                    res
);

  import lir_pkg::*;

  localparam int GIDX_W     = $clog2(GRID_POINTS);
  localparam int CUR_W      = $clog2(GRID_POINTS + 1);
  localparam int FLUX_DEPTH = MODEL_SETS * TIME_STEPS * GRID_POINTS;
  localparam int FA_W       = $clog2(FLUX_DEPTH);
  localparam int SCALED_W   = PROD_W - FRAC_W;

  localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;
  localparam logic [FLUX_W-1:0]   FLUX_MAX   = {1'b0, {(FLUX_W-1){1'b1}}};
  localparam logic [FLUX_W-1:0]   FLUX_MIN   = {1'b1, {(FLUX_W-1){1'b0}}};

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_LOAD     = 12'b0000_0000_0010,
    S_WALK     = 12'b0000_0000_0100,
    S_CMP      = 12'b0000_0000_1000,
    S_OTHER    = 12'b0000_0001_0000,
    S_PREP     = 12'b0000_0010_0000,
    S_DIV      = 12'b0000_0100_0000,
    S_FLUX_LO  = 12'b0000_1000_0000,
    S_FLUX_HI  = 12'b0001_0000_0000,
    S_FLUX_CAP = 12'b0010_0000_0000,
    S_MULT     = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state;

  logic [WL_W-1:0]   grid_mem [GRID_POINTS];
  logic [FLUX_W-1:0] flux_mem [FLUX_DEPTH];
  logic [WL_W-1:0]   grid_rdata;
  logic [FLUX_W-1:0] flux_rdata;
  logic [GIDX_W-1:0] grid_raddr;
  logic [FA_W-1:0]   flux_addr;

  mode_t              q_mode;
  logic [GRID_IDX_W-1:0] q_grid_index;
  logic [TIME_W-1:0]  q_time;
  logic [METAL_W-1:0] q_metal;
  logic [SET_W-1:0]   q_set;
  logic               q_flux_ok;
  logic [WL_W-1:0]    q_wl;
  logic [FLUX_W-1:0]  q_flux;

  logic [CUR_W-1:0]    cursor;
  logic [CUR_W-1:0]    n_use;
  logic [WL_W-1:0]     g_cur;
  logic [WL_W-1:0]     g_other;
  logic [WEIGHT_W-1:0] wu;
  logic [FLUX_W-1:0]   f_lo;

  logic                in_fire;
  logic                at_start;
  logic [CUR_W-1:0]    low_idx;
  logic [CUR_W-1:0]    high_idx;
  logic [CUR_W-1:0]    other_idx;
  logic [WL_W-1:0]     g_low;
  logic [WL_W-1:0]     g_high;
  logic [WL_W:0]       delta;
  logic [WL_W:0]       num;
  logic                delta_pos;
  logic                num_pos;
  logic [SET_W-1:0]    fa_set;
  logic [TIME_W-1:0]   fa_time;
  logic [CUR_W-1:0]    fa_point;
  logic [FLUX_W-1:0]   flux_hi_val;
  logic [PROD_W-1:0]   total;
  logic [SCALED_W-1:0] scaled;
  logic [FLUX_W-1:0]   sat_flux;
  logic                grid_we;
  logic                flux_we;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign res_valid   = (state == S_DONE);

  always_comb begin
    if (32'(grid_count) < 32'd2) begin
      n_use = CUR_W'(2);
    end else if (32'(grid_count) > GRID_POINTS) begin
      n_use = CUR_W'(GRID_POINTS);
    end else begin
      n_use = CUR_W'(grid_count);
    end
  end

  assign at_start  = (cursor == '0);
  assign low_idx   = at_start ? '0 : cursor - 1'b1;
  assign high_idx  = at_start ? CUR_W'(1) : cursor;
  assign other_idx = at_start ? CUR_W'(1) : cursor - 1'b1;
  assign g_low     = at_start ? g_cur : g_other;
  assign g_high    = at_start ? g_other : g_cur;
  assign delta     = {1'b0, g_high} - {1'b0, g_low};
  assign num       = {1'b0, q_wl} - {1'b0, g_low};
  assign delta_pos = !delta[WL_W] && (delta != '0);
  assign num_pos   = !num[WL_W] && (num != '0);

  assign div_num     = num[WL_W-1:0];
  assign div_den     = delta[WL_W-1:0];
  assign div_start   = (state == S_PREP) && delta_pos && num_pos && (num < delta);
  assign flux_hi_val = q_flux_ok ? flux_rdata : '0;
  assign mult_mcand  = {flux_hi_val[FLUX_W-1], flux_hi_val} - {f_lo[FLUX_W-1], f_lo};
  assign mult_mplier = wu;
  assign mult_start  = (state == S_FLUX_CAP);

  assign total  = mult_prod
                + ({{(PROD_W-FLUX_W){f_lo[FLUX_W-1]}}, f_lo} << FRAC_W)
                + ROUND_HALF;
  assign scaled = total[PROD_W-1:FRAC_W];

  always_comb begin
    if ((&scaled[SCALED_W-1:FLUX_W-1]) || !(|scaled[SCALED_W-1:FLUX_W-1])) begin
      sat_flux = scaled[FLUX_W-1:0];
    end else if (scaled[SCALED_W-1]) begin
      sat_flux = FLUX_MIN;
    end else begin
      sat_flux = FLUX_MAX;
    end
  end

  always_comb begin
    case (state)
      S_CMP:   grid_raddr = other_idx[GIDX_W-1:0];
      default: grid_raddr = cursor[GIDX_W-1:0];
    endcase
  end

  always_comb begin
    case (state)
      S_LOAD: begin
        fa_set   = SET_W'(q_metal);
        fa_point = CUR_W'(q_grid_index);
      end
      S_FLUX_LO: begin
        fa_set   = q_set;
        fa_point = low_idx;
      end
      default: begin
        fa_set   = q_set;
        fa_point = high_idx;
      end
    endcase
    fa_time   = q_time;
    flux_addr = FA_W'((32'(fa_set) * TIME_STEPS + 32'(fa_time)) * GRID_POINTS
                      + 32'(fa_point));
  end

  assign grid_we = (state == S_LOAD) && (q_mode == MODE_LOAD_GRID)
                && (32'(q_grid_index) < GRID_POINTS);
  assign flux_we = (state == S_LOAD) && (q_mode == MODE_LOAD_FLUX)
                && (32'(q_grid_index) < GRID_POINTS)
                && (32'(q_time) < TIME_STEPS)
                && (32'(q_metal) < MODEL_SETS);

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[GIDX_W'(q_grid_index)] <= q_wl;
    end
    grid_rdata <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (flux_we) begin
      flux_mem[flux_addr] <= q_flux;
    end
    flux_rdata <= flux_mem[flux_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.payload.mode)
              MODE_LOAD_GRID: state <= S_LOAD;
              MODE_LOAD_FLUX: state <= S_LOAD;
              MODE_QUERY:     state <= S_WALK;
              MODE_RESTART:   cursor <= '0;
              default:        state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state <= S_IDLE;
        S_WALK: begin
          if (cursor >= n_use) begin
            state <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (q_wl > grid_rdata) begin
            cursor <= cursor + 1'b1;
            state  <= S_WALK;
          end else if (at_start && (q_wl < grid_rdata)) begin
            state <= S_DONE;
          end else begin
            state <= S_OTHER;
          end
        end
        S_OTHER: state <= S_PREP;
        S_PREP: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= S_FLUX_LO;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FLUX_LO;
          end
        end
        S_FLUX_LO:  state <= S_FLUX_HI;
        S_FLUX_HI:  state <= S_FLUX_CAP;
        S_FLUX_CAP: state <= S_MULT;
        S_MULT: begin
          if (mult_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_mode       <= in_ch.payload.mode;
      q_grid_index <= in_ch.payload.grid_index;
      q_time       <= in_ch.payload.time_index;
      q_metal      <= in_ch.payload.metal_index;
      q_set        <= SET_W'(in_ch.payload.metal_index)
                    + (imf_select ? SET_W'(SETS_PER_FAMILY) : '0);
      q_flux_ok    <= (32'(SET_W'(in_ch.payload.metal_index)
                         + (imf_select ? SET_W'(SETS_PER_FAMILY) : '0)) < MODEL_SETS)
                   && (32'(in_ch.payload.time_index) < TIME_STEPS);
      q_wl         <= in_ch.payload.wavelength;
      q_flux       <= in_ch.payload.flux;
    end
    case (state)
      S_WALK: begin
        if (cursor >= n_use) begin
          res.interpolated_flux <= '0;
          res.range_error       <= RANGE_ABOVE;
          res.low_point         <= '0;
        end
      end
      S_CMP: begin
        g_cur <= grid_rdata;
        if (at_start && (q_wl < grid_rdata)) begin
          res.interpolated_flux <= '0;
          res.range_error       <= RANGE_BELOW;
          res.low_point         <= '0;
        end
      end
      S_OTHER: g_other <= grid_rdata;
      S_PREP: begin
        if (!delta_pos || !num_pos) begin
          wu <= '0;
        end else if (num >= delta) begin
          wu <= WEIGHT_ONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          wu <= {1'b0, div_quo};
        end
      end
      S_FLUX_HI: f_lo <= q_flux_ok ? flux_rdata : '0;
      S_MULT: begin
        if (mult_done) begin
          res.interpolated_flux <= sat_flux;
          res.range_error       <= RANGE_OK;
          res.low_point         <= GRID_IDX_W'(low_idx);
        end
      end
      default: ;
    endcase
  end

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cursor) <= GRID_POINTS)
    else $error("cursor beyond grid");

  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_CMP) && !in_fire |=> $stable(cursor))
    else $error("cursor moved outside walk");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside division wait");

  a_mult_done_state: assert property (@(posedge clk) disable iff (rst)
    mult_done |-> (state == S_MULT))
    else $error("multiplier finished outside product wait");

endmodule

`default_nettype wire

// ===== hdl/linear_interp_resampler_top.sv =====
// ---------------------------------------------------------------------------
// linear_interp_resampler_top: linear interpolation resampler
// Resamples stored model spectra onto ascending target wavelengths.
//
// in_ch carries load, query and restart items; out_ch carries one result
// per query. cfg_we/cfg_index/cfg_data write grid_count and imf_select;
// write them only while the block is idle.
// A grid or flux load passes through the load state; a restart is taken in
// the idle state. A query walks the grid, with a grid memory read and a
// compare for each grid point the cursor advances, then reads the other
// bracketing point, runs the bit-serial divider for the upper weight,
// reads the two flux samples and runs the bit-serial multiplier.
// A query whose upper weight is zero or one skips the divider.
// The result appears on out_ch in the same cycle as in_ch turns ready.
// A query above the grid finishes right after the walk, one below the grid
// at its first compare.
// Reset clears the cursor, the sequencer and the output valid flag and sets
// grid_count to 256 and imf_select to 0; the grid and flux memories are not
// cleared and must be loaded before use.
// A finished result sits in the output register while the receiver stalls;
// loads and restarts are still taken, and the next query result waits
// in the sequencer until the output register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler_top #(
  parameter int GRID_POINTS = lir_pkg::DEF_GRID_POINTS,
  parameter int TIME_STEPS  = lir_pkg::DEF_TIME_STEPS,
  parameter int MODEL_SETS  = lir_pkg::DEF_MODEL_SETS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lir_stream_if.sink                           in_ch,
  lir_stream_if.source                         out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [lir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lir_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import lir_pkg::*;

  logic [GRID_COUNT_W-1:0] grid_count;
  logic                    imf_select;

  logic                div_start;
  logic [WL_W-1:0]     div_num;
  logic [WL_W-1:0]     div_den;
  logic                div_done;
  logic [FRAC_W-1:0]   div_quo;
  logic                mult_start;
  logic [DIFF_W-1:0]   mult_mcand;
  logic [WEIGHT_W-1:0] mult_mplier;
  logic                mult_done;
  logic [PROD_W-1:0]   mult_prod;
  logic                res_valid;
  logic                res_ready;
  out_item_t           res;

  logic      out_valid;
  out_item_t out_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_count <= GRID_COUNT_RESET;
      imf_select <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_COUNT: grid_count <= cfg_data[GRID_COUNT_W-1:0];
        CFG_IMF_SELECT: imf_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lir_ctrl #(
    .GRID_POINTS (GRID_POINTS),
    .TIME_STEPS  (TIME_STEPS),
    .MODEL_SETS  (MODEL_SETS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .grid_count  (grid_count),
    .imf_select  (imf_select),
    .div_start   (div_start),
    .div_num     (div_num),
    .div_den     (div_den),
    .div_done    (div_done),
    .div_quo     (div_quo),
    .mult_start  (mult_start),
    .mult_mcand  (mult_mcand),
    .mult_mplier (mult_mplier),
    .mult_done   (mult_done),
    .mult_prod   (mult_prod),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  lir_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  lir_serial_mult u_mult (
    .clk    (clk),
    .rst    (rst),
    .start  (mult_start),
    .mcand  (mult_mcand),
    .mplier (mult_mplier),
    .done   (mult_done),
    .prod   (mult_prod)
  );

  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_payload <= res;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_payload;

endmodule

`default_nettype wire

// ===== sim/linear_interp_resampler_top_tb.sv =====
// ---------------------------------------------------------------------------
// linear_interp_resampler_top_tb: self-checking bench of the resampler
// Loads grids and flux tables, sends directed and random query passes through
// several grid sizes and model families, predicts every interpolated result
// and compares it field by field, with random idling on both channels and
// one long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_interp_resampler_top_tb;

  import lir_pkg::*;

  localparam int GRID_POINTS = DEF_GRID_POINTS;
  localparam int TIME_STEPS  = DEF_TIME_STEPS;
  localparam int MODEL_SETS  = DEF_MODEL_SETS;
  localparam int FLUX_DEPTH  = MODEL_SETS * TIME_STEPS * GRID_POINTS;
  localparam int MAX_CYCLES  = 1000000;
  localparam int MAX_WL      = 24'hFF_FFFF;

  typedef struct {
    in_item_t  item;
    bit        has_res;
    out_item_t res;
  } pending_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lir_stream_if #(.payload_t(in_item_t))  in_ch ();
  lir_stream_if #(.payload_t(out_item_t)) out_ch ();

  linear_interp_resampler_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [WL_W-1:0]          grid_wl [GRID_POINTS];
  logic signed [FLUX_W-1:0] flux_store [FLUX_DEPTH];
  bit                       flux_known [FLUX_DEPTH];
  logic [GRID_COUNT_W-1:0]  walk_pos;
  int                       cfg_points;
  bit                       cfg_family;

  pending_t  pending_items[$];
  out_item_t expected_resamples[$];

  int items_taken = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int hold_left;
  bit hold_done;
  wire steady = (items_taken >= 600) && (items_taken < 800);

  function automatic int pts_in_use();
    if (cfg_points < 2) return 2;
    if (cfg_points > GRID_POINTS) return GRID_POINTS;
    return cfg_points;
  endfunction

  function automatic int flux_addr(int set_id, int t, int p);
    return (set_id * TIME_STEPS + t) * GRID_POINTS + p;
  endfunction

  function automatic longint stored_flux(int set_id, int t, int p);
    if (set_id >= MODEL_SETS || t >= TIME_STEPS) return 0;
    return longint'(flux_store[flux_addr(set_id, t, p)]);
  endfunction

  function automatic int query_set(logic [METAL_W-1:0] mi);
    return int'(mi) + (cfg_family ? SETS_PER_FAMILY : 0);
  endfunction

  function automatic void bracket_target(input logic [WL_W-1:0] wl,
                                         output logic [GRID_COUNT_W-1:0] stop,
                                         output range_t rng, output int lo,
                                         output int hi);
    int n;
    n = pts_in_use();
    stop = walk_pos;
    while (stop < n && wl > grid_wl[stop]) stop++;
    lo = 0;
    hi = 1;
    rng = RANGE_OK;
    if (stop >= n) rng = RANGE_ABOVE;
    else if (stop == 0) begin
      if (wl < grid_wl[0]) rng = RANGE_BELOW;
    end else begin
      hi = stop;
      lo = stop - 1;
    end
  endfunction

  function automatic out_item_t interpolate_query(in_item_t it);
    logic [GRID_COUNT_W-1:0] stop;
    range_t    rng;
    int        lo, hi, set_id;
    longint    delta, num, wu, wd, acc, r;
    out_item_t res;
    bracket_target(it.wavelength, stop, rng, lo, hi);
    walk_pos = stop;
    res = '0;
    res.range_error = rng;
    if (rng != RANGE_OK) return res;
    delta = longint'(grid_wl[hi]) - longint'(grid_wl[lo]);
    num = longint'(it.wavelength) - longint'(grid_wl[lo]);
    if (delta <= 0 || num <= 0) wu = 0;
    else begin
      wu = (num * 65536) / delta;
      if (wu > 65536) wu = 65536;
    end
    wd = 65536 - wu;
    set_id = query_set(it.metal_index);
    acc = wd * stored_flux(set_id, it.time_index, lo)
        + wu * stored_flux(set_id, it.time_index, hi);
    r = (acc + 32768) >>> FRAC_W;
    if (r > longint'(32'sh7FFF_FFFF)) r = longint'(32'sh7FFF_FFFF);
    if (r < longint'(32'sh8000_0000)) r = longint'(32'sh8000_0000);
    res.interpolated_flux = r[FLUX_W-1:0];
    res.low_point = lo[GRID_IDX_W-1:0];
    return res;
  endfunction

  function automatic void enqueue(mode_t m, int gi, int ti, int mi, int wl,
                                  logic [FLUX_W-1:0] fx);
    pending_t p;
    int       addr;
    p.item.mode        = m;
    p.item.grid_index  = GRID_IDX_W'(gi);
    p.item.time_index  = TIME_W'(ti);
    p.item.metal_index = METAL_W'(mi);
    p.item.wavelength  = WL_W'(wl);
    p.item.flux        = fx;
    p.has_res = 1'b0;
    p.res = '0;
    case (m)
      MODE_LOAD_GRID: grid_wl[p.item.grid_index] = p.item.wavelength;
      MODE_LOAD_FLUX: begin
        if (p.item.metal_index < MODEL_SETS) begin
          addr = flux_addr(p.item.metal_index, p.item.time_index, p.item.grid_index);
          flux_store[addr] = fx;
          flux_known[addr] = 1'b1;
        end
      end
      MODE_RESTART: walk_pos = '0;
      default: begin
        p.has_res = 1'b1;
        p.res = interpolate_query(p.item);
      end
    endcase
    pending_items = {pending_items, p};
  endfunction

  function automatic logic [FLUX_W-1:0] random_flux();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(131071)) - 32'd65536;
      default: return $urandom();
    endcase
  endfunction

  // load any flux sample not yet loaded that the query will interpolate from, then queue the query
  function automatic void query(int wl, int ti, int mi);
    logic [GRID_COUNT_W-1:0] stop;
    range_t rng;
    int     lo, hi, set_id;
    set_id = query_set(METAL_W'(mi));
    if (set_id < MODEL_SETS) begin
      bracket_target(WL_W'(wl), stop, rng, lo, hi);
      if (rng == RANGE_OK) begin
        if (!flux_known[flux_addr(set_id, ti, lo)])
          enqueue(MODE_LOAD_FLUX, lo, ti, set_id, $urandom(), random_flux());
        if (!flux_known[flux_addr(set_id, ti, hi)])
          enqueue(MODE_LOAD_FLUX, hi, ti, set_id, $urandom(), random_flux());
      end
    end
    enqueue(MODE_QUERY, $urandom_range(255), ti, mi, wl, $urandom());
  endfunction

  function automatic void load_grid(int npts);
    int base, step_max, v;
    base = ($urandom_range(3) == 0) ? 0 : $urandom_range(24'h7F_FFFF);
    step_max = (MAX_WL - base) / npts;
    if (step_max > 8000) step_max = 8000;
    v = base;
    for (int i = 0; i < npts; i++) begin
      if (i > 0) begin
        if ($urandom_range(99) < 6) v = v - $urandom_range(step_max);
        else v = v + $urandom_range(step_max, 1);
      end
      if (v < 0) v = 0;
      if (v > MAX_WL) v = MAX_WL;
      enqueue(MODE_LOAD_GRID, i, $urandom_range(15), $urandom_range(15), v, $urandom());
    end
  endfunction

  function automatic void run_queries(int npts, int nops);
    int span, step_max, start, tgt, roll, mi;
    span = int'(grid_wl[npts-1]) - int'(grid_wl[0]);
    if (span < 40) span = 40;
    step_max = span / 20;
    start = int'(grid_wl[0]) - $urandom_range(step_max);
    if (start < 0) start = 0;
    tgt = start;
    for (int k = 0; k < nops; k++) begin
      roll = $urandom_range(99);
      mi = ($urandom_range(99) < 85) ? $urandom_range(5) : $urandom_range(15, 6);
      if (roll < 10) begin
        enqueue(MODE_LOAD_FLUX, $urandom_range(255), $urandom_range(15),
                $urandom_range(15), $urandom(), random_flux());
      end else if (roll < 14) begin
        enqueue(MODE_LOAD_GRID, $urandom_range(npts - 1), $urandom_range(15),
                $urandom_range(15), $urandom_range(MAX_WL), $urandom());
      end else if (roll < 18 || tgt > int'(grid_wl[npts-1]) + step_max) begin
        enqueue(MODE_RESTART, $urandom_range(255), $urandom_range(15),
                $urandom_range(15), $urandom(), $urandom());
        tgt = start;
      end else if (roll < 30) begin
        query($urandom_range(MAX_WL), $urandom_range(15), mi);
      end else begin
        tgt = tgt + $urandom_range(step_max);
        if (tgt > MAX_WL) tgt = MAX_WL;
        query(tgt, $urandom_range(15), mi);
      end
    end
  endfunction

  task automatic wait_idle(int settle);
    do @(negedge clk);
    while (pending_items.size() != 0 || expected_resamples.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_config(int count, bit fam);
    wait_idle(20);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_COUNT;
    cfg_data  <= 9'(count);
    @(posedge clk);
    cfg_index <= CFG_IMF_SELECT;
    cfg_data  <= {8'd0, fam};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cfg_points = count;
    cfg_family = fam;
  endtask

  function automatic void check_resample(out_item_t got);
    out_item_t want;
    if (expected_resamples.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: flux=%h range=%0d low=%0d",
                 got.interpolated_flux, got.range_error, got.low_point);
      return;
    end
    want = expected_resamples.pop_front();
    if (got.interpolated_flux !== want.interpolated_flux ||
        got.range_error !== want.range_error || got.low_point !== want.low_point) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected flux=%h range=%0d low=%0d, got flux=%h range=%0d low=%0d",
                 want.interpolated_flux, want.range_error, want.low_point,
                 got.interpolated_flux, got.range_error, got.low_point);
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.payload <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (pending_items[0].has_res)
          expected_resamples = {expected_resamples, pending_items[0].res};
        pending_items.delete(0);
        items_taken <= items_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() > 0 && (steady || $urandom_range(99) >= 28)) begin
          in_ch.valid   <= 1'b1;
          in_ch.payload <= pending_items[0].item;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_resample(out_ch.payload);
      out_ch.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 28);
    end
  end

  // hold off the result side once so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_taken >= 250) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("[linear_interp_resampler_top] ERROR");
      $finish;
    end
  end

  initial begin
    int count;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    walk_pos      = '0;
    cfg_points    = GRID_COUNT_RESET;
    cfg_family    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_config(4, 1'b0);
    enqueue(MODE_LOAD_GRID, 0, 0, 0, 1000, '0);
    enqueue(MODE_LOAD_GRID, 1, 0, 0, 2000, '0);
    enqueue(MODE_LOAD_GRID, 2, 0, 0, 1500, '0);
    enqueue(MODE_LOAD_GRID, 3, 0, 0, 3000, '0);
    enqueue(MODE_LOAD_GRID, 255, 15, 15, MAX_WL, 32'hFFFF_FFFF);
    enqueue(MODE_LOAD_GRID, 254, 0, 0, 0, '0);
    enqueue(MODE_LOAD_FLUX, 255, 15, 13, MAX_WL, 32'h8000_0000);
    enqueue(MODE_LOAD_FLUX, 0, 0, 0, 0, 32'h7FFF_FFFF);
    enqueue(MODE_LOAD_FLUX, 1, 0, 0, 0, 32'h8000_0000);
    enqueue(MODE_LOAD_FLUX, 2, 0, 0, 0, 32'h7FFF_FFFF);
    enqueue(MODE_LOAD_FLUX, 3, 0, 0, 0, 32'h8000_0000);
    query(0, 0, 0);
    query(1000, 0, 0);
    query(1800, 0, 0);
    query(2500, 0, 0);
    query(900, 0, 0);
    enqueue(MODE_LOAD_GRID, 2, 0, 0, 3500, '0);
    query(2800, 0, 0);
    query(2900, 15, 15);
    query(MAX_WL, 0, 0);
    query(1200, 0, 0);
    enqueue(MODE_RESTART, 0, 0, 0, 0, '0);
    query(1000, 15, 5);
    query(MAX_WL, 0, 0);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: count = 2;
        1: count = GRID_POINTS;
        default: count = $urandom_range(40, 3);
      endcase
      set_config(count, (p == 0) ? 1'b1 : 1'($urandom_range(1)));
      load_grid(count);
      if (p != 0 && $urandom_range(99) < 70)
        enqueue(MODE_RESTART, 0, 0, 0, 0, '0);
      run_queries(count, (p == 1) ? 60 : 40);
    end

    wait_idle(100);
    if (mismatches == 0) begin
      $display("[linear_interp_resampler_top] OK");
    end else begin
      $display("[linear_interp_resampler_top] ERROR");
    end
    $finish;
  end

endmodule
